### sv/gtpuhc_pkg.sv
package gtpuhc_pkg;

	// header layout
	localparam int unsigned HDR_BYTES = 8;
	localparam int unsigned OPT_BYTES = 4;
	localparam int unsigned MAX_DATAGRAM_DEF = 4096;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned TEID_W = 32;
	localparam int unsigned OPT_W = 3;
	localparam logic [2:0] GTP_VERSION = 3'd1;

	// header byte positions
	localparam int unsigned POS_FLAGS = 0;
	localparam int unsigned POS_LEN_HI = 2;
	localparam int unsigned POS_LEN_LO = 3;
	localparam int unsigned POS_TEID_LO = 4;

	// flag bits of byte 0
	localparam int unsigned FLAG_E = 2;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_SHORT_HEADER = 3'd1,
		ST_BAD_VERSION  = 3'd2,
		ST_EXTENSION    = 3'd3,
		ST_SHORT_OPT    = 3'd4,
		ST_LEN_MISMATCH = 3'd5
	} status_t;

	typedef struct packed {
		logic          payload_valid;
		logic [7:0]    payload_byte;
		logic          end_of_datagram;
		status_t       check_status;
		logic [31:0]   tunnel_id;
	} result_t;

endpackage

### sv/gtpuhc_parser.sv
module gtpuhc_parser #(
	parameter int unsigned MAX_DATAGRAM = gtpuhc_pkg::MAX_DATAGRAM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output logic                 has_result,
	output gtpuhc_pkg::result_t  result
);

	localparam int unsigned PW = $clog2(MAX_DATAGRAM + 1);
	localparam int unsigned LW = gtpuhc_pkg::LEN_W;
	localparam int unsigned TW = gtpuhc_pkg::TEID_W;
	localparam int unsigned OW = gtpuhc_pkg::OPT_W;

	logic [PW-1:0] pos_q, pos_n;
	logic [7:0]    flags_q, flags_n;
	logic [LW-1:0] len_q, len_n;
	logic [TW-1:0] teid_q, teid_n;
	logic [OW-1:0] opt_q, opt_n;
	logic          in_range, payload;
	gtpuhc_pkg::status_t status;

	// per-byte state update
	always_comb begin
		pos_n = pos_q;
		flags_n = flags_q;
		len_n = len_q;
		teid_n = teid_q;
		opt_n = opt_q;
		payload = 1'b0;
		in_range = pos_q < PW'(MAX_DATAGRAM);
		if (in_range) begin
			if (pos_q == PW'(gtpuhc_pkg::POS_FLAGS)) begin
				flags_n = data_byte;
				opt_n = (|data_byte[2:0]) ? OW'(gtpuhc_pkg::OPT_BYTES) : '0;
			end else if (pos_q == PW'(gtpuhc_pkg::POS_LEN_HI) ||
					pos_q == PW'(gtpuhc_pkg::POS_LEN_LO)) begin
				len_n = {len_q[LW-9:0], data_byte};
			end else if (pos_q >= PW'(gtpuhc_pkg::POS_TEID_LO) &&
					pos_q < PW'(gtpuhc_pkg::HDR_BYTES)) begin
				teid_n = {teid_q[TW-9:0], data_byte};
			end else if (pos_q >= PW'(gtpuhc_pkg::HDR_BYTES) + PW'(opt_q)) begin
				payload = 1'b1;
			end
			pos_n = pos_q + PW'(1);
		end
	end

	// status from the state after this byte
	always_comb begin
		if (pos_n < PW'(gtpuhc_pkg::HDR_BYTES))
			status = gtpuhc_pkg::ST_SHORT_HEADER;
		else if (flags_n[7:5] != gtpuhc_pkg::GTP_VERSION)
			status = gtpuhc_pkg::ST_BAD_VERSION;
		else if (flags_n[gtpuhc_pkg::FLAG_E])
			status = gtpuhc_pkg::ST_EXTENSION;
		else if (pos_n < PW'(gtpuhc_pkg::HDR_BYTES) + PW'(opt_n))
			status = gtpuhc_pkg::ST_SHORT_OPT;
		else if (len_n < LW'(opt_n) ||
				LW'(pos_n - PW'(gtpuhc_pkg::HDR_BYTES)) != len_n)
			status = gtpuhc_pkg::ST_LEN_MISMATCH;
		else
			status = gtpuhc_pkg::ST_OK;
	end

	always_comb begin
		has_result = payload | last_byte;
		result.payload_valid = payload;
		result.payload_byte = payload ? data_byte : 8'd0;
		result.end_of_datagram = last_byte;
		result.check_status = last_byte ? status : gtpuhc_pkg::ST_OK;
		result.tunnel_id = last_byte ? teid_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			flags_q <= '0;
			len_q <= '0;
			teid_q <= '0;
			opt_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				pos_q <= '0;
				flags_q <= '0;
				len_q <= '0;
				teid_q <= '0;
				opt_q <= '0;
			end else begin
				pos_q <= pos_n;
				flags_q <= flags_n;
				len_q <= len_n;
				teid_q <= teid_n;
				opt_q <= opt_n;
			end
		end
	end

endmodule

### sv/gtpuhc_out_reg.sv
module gtpuhc_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  gtpuhc_pkg::result_t  result,
	output logic                 free,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [47:0]          m_axis_tdata,
	output logic                 m_axis_tuser,
	output logic                 m_axis_tlast
);

	logic                valid_q;
	gtpuhc_pkg::result_t data_q;

	assign free = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tlast = data_q.end_of_datagram;
	assign m_axis_tuser = data_q.payload_valid;
	assign m_axis_tdata = {5'd0, data_q.tunnel_id, data_q.check_status, data_q.payload_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= result;
		end
	end

endmodule

### sv/gtpu_header_checker_top.sv
// gtp-u v1 header checker: takes a received datagram one byte per request on the
// slave stream (tlast on the final byte), parses the 8-byte header (flags, big-endian
// length, big-endian tunnel id), skips the 4 optional bytes when s, pn or e is set and
// passes every later byte on as a payload request. the final byte always yields a
// request with tlast high carrying the check status and tunnel id; bytes that are
// neither payload nor final yield nothing. payload goes out before the status is known,
// so only the status on the final request says whether the datagram was good. beyond
// MAX_DATAGRAM bytes, further bytes are dropped until the final one. throughput is one
// byte per cycle unless the receiver stalls; path: input register, one pass of parse
// logic, and an output register; the per-datagram state registers close the only loop.
module gtpu_header_checker_top #(
	parameter int unsigned MAX_DATAGRAM = gtpuhc_pkg::MAX_DATAGRAM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream: datagram bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	// master stream: results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] check_status,
	                                    // [42:11] tunnel_id, rest 0
	output logic        m_axis_tuser,   // payload_valid
	output logic        m_axis_tlast    // end_of_datagram
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic                out_free;
	logic                advance;
	logic                has_result;
	gtpuhc_pkg::result_t result;

	// a byte moves on whenever the output register can take a result
	assign advance = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// header parse and per-datagram state
	gtpuhc_parser #(
		.MAX_DATAGRAM(MAX_DATAGRAM)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.data_byte(byte_s1),
		.last_byte(last_s1),
		.has_result(has_result),
		.result(result)
	);

	// result register
	gtpuhc_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance && has_result),
		.result(result),
		.free(out_free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

`ifndef SYNTH
	// status only on the final request of a datagram
	a_status_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[42:8] == '0)
		else $error("status or tunnel id outside final request");

	// every request is payload or a datagram end
	a_request_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser || m_axis_tlast)
		else $error("empty result request");

	// a stalled byte stays in the input register
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input stage lost a byte");
`endif

endmodule

### verif/tb_gtpu_header_checker_top.sv
module tb_gtpu_header_checker_top;

	import gtpuhc_pkg::*;

	localparam int unsigned MAX_BYTES   = MAX_DATAGRAM_DEF;
	localparam int          QUIET_LIMIT = 4000;  // cycles with no request moving on either side
	localparam int          HOLD_CYCLES = 400;   // long receiver hold-off, fills the block
	localparam int          HOLD_AT     = 100;   // results seen before the long hold-off
	localparam int          ITEM_TARGET = 700;
	localparam int          DRAIN_WAIT  = 12;    // extra wait once no result is pending

	typedef logic [7:0] byte_q_t[$];

	// predicts the checker output for each accepted byte and holds the expected results
	class gtpu_scoreboard;
		int unsigned position;
		logic [7:0]  flags;
		logic [15:0] decl_len;
		logic [31:0] teid;
		int unsigned opt_len;
		result_t     expected_q[$];
		int          errors;
		int          results_seen;
		int          bytes_in;
		int          payload_bytes;
		int          datagrams;
		int          status_count[6];

		function void clear_datagram();
			position = 0;
			flags    = '0;
			decl_len = '0;
			teid     = '0;
			opt_len  = 0;
		endfunction

		function new();
			clear_datagram();
			errors       = 0;
			results_seen = 0;
			bytes_in     = 0;
			payload_bytes = 0;
			datagrams    = 0;
			foreach (status_count[i])
				status_count[i] = 0;
		endfunction

		function status_t datagram_status();
			if (position < HDR_BYTES)
				return ST_SHORT_HEADER;
			if (flags[7:5] != GTP_VERSION)
				return ST_BAD_VERSION;
			if (flags[FLAG_E])
				return ST_EXTENSION;
			if (position < HDR_BYTES + opt_len)
				return ST_SHORT_OPT;
			if (decl_len < opt_len || position - HDR_BYTES != decl_len)
				return ST_LEN_MISMATCH;
			return ST_OK;
		endfunction

		function void note_request(logic [7:0] b, logic last);
			logic    hit;
			result_t r;
			hit = 1'b0;
			bytes_in++;
			if (position < MAX_BYTES) begin
				if (position == POS_FLAGS) begin
					flags   = b;
					opt_len = (b[2:0] != 3'd0) ? OPT_BYTES : 0;
				end else if (position == POS_LEN_HI || position == POS_LEN_LO) begin
					decl_len = {decl_len[7:0], b};
				end else if (position >= POS_TEID_LO && position < HDR_BYTES) begin
					teid = {teid[23:0], b};
				end else if (position >= HDR_BYTES + opt_len) begin
					hit = 1'b1;
				end
				position++;
			end
			if (!hit && !last)
				return;
			r.payload_valid   = hit;
			r.payload_byte    = hit ? b : 8'd0;
			r.end_of_datagram = last;
			r.check_status    = last ? datagram_status() : ST_OK;
			r.tunnel_id       = last ? teid : 32'd0;
			expected_q.push_back(r);
			if (hit)
				payload_bytes++;
			if (last) begin
				datagrams++;
				status_count[r.check_status]++;
				clear_datagram();
			end
		endfunction

		task report_mismatch(string field, longint unsigned got, longint unsigned want);
			errors++;
			if (errors <= 40)
				$display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
					results_seen, field, got, want);
		endtask

		task check_result(logic [47:0] d, logic user, logic last);
			result_t w;
			results_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result, tdata", d, 0);
				return;
			end
			w = expected_q.pop_front();
			if (user !== w.payload_valid)
				report_mismatch("payload_valid", user, w.payload_valid);
			if (d[7:0] !== w.payload_byte)
				report_mismatch("payload_byte", d[7:0], w.payload_byte);
			if (last !== w.end_of_datagram)
				report_mismatch("end_of_datagram", last, w.end_of_datagram);
			if (d[10:8] !== w.check_status)
				report_mismatch("check_status", d[10:8], w.check_status);
			if (d[42:11] !== w.tunnel_id)
				report_mismatch("tunnel_id", d[42:11], w.tunnel_id);
			if (d[47:43] !== 5'd0)
				report_mismatch("tdata padding", d[47:43], 0);
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	gtpu_scoreboard sb;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int quiet_cycles = 0;
	int normal_items = 0;

	gtpu_header_checker_top #(
		.MAX_DATAGRAM(MAX_BYTES)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: any request moving on either side restarts the count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// one byte request; the gap before it is drawn per byte when idling is on
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(b, last);
	endtask

	task automatic send_datagram(input byte_q_t q);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
	endtask

	// mostly well-formed datagrams with random content, some broken ones and some noise
	function automatic byte_q_t make_datagram();
		byte_q_t     q;
		int          kind;
		int          n;
		int          opt;
		int          keep;
		logic [7:0]  flags;
		logic [15:0] len;
		kind = $urandom_range(0, 99);
		if (kind >= 95) begin
			// pure noise, any first byte and any length
			n = $urandom_range(1, 30);
			repeat (n) q.push_back(8'($urandom_range(0, 255)));
			return q;
		end
		// version 1, random pt and spare bits, random s and pn, e rarely
		flags = {GTP_VERSION, 2'($urandom_range(0, 3)), 1'b0, 2'($urandom_range(0, 3))};
		if ($urandom_range(0, 9) == 0)
			flags[FLAG_E] = 1'b1;
		n   = $urandom_range(0, 16);
		opt = (flags[2:0] != 3'd0) ? OPT_BYTES : 0;
		len = 16'(opt + n);
		if (kind >= 60 && kind < 80) begin
			case ($urandom_range(0, 3))
				0: flags[7:5] = 3'($urandom_range(0, 7));
				1: flags[FLAG_E] = 1'b1;
				2: len = 16'($urandom_range(0, 65535));
				default: len = len + 16'($urandom_range(1, 3)) - 16'd2;
			endcase
			opt = (flags[2:0] != 3'd0) ? OPT_BYTES : 0;
		end
		q.push_back(flags);
		q.push_back(8'($urandom_range(0, 255)));
		q.push_back(len[15:8]);
		q.push_back(len[7:0]);
		repeat (4 + opt + n) q.push_back(8'($urandom_range(0, 255)));
		// truncated datagrams: most are cut within the first 12 bytes, the rest at any length
		if (kind >= 80)
			keep = $urandom_range(1, (q.size() < 12) ? q.size() : 12);
		else if (kind >= 75)
			keep = $urandom_range(1, q.size());
		else
			keep = q.size();
		while (q.size() > keep)
			void'(q.pop_back());
		return q;
	endfunction

	// receiver: random stalls in phases, plus one long hold-off
	initial begin
		int  stall;
		bit  hold_done;
		hold_done = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!hold_done && sb.results_seen >= HOLD_AT) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			if ($urandom_range(0, 39) == 0)
				rx_idle_on = !rx_idle_on;
			stall = rx_idle_on ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	end

	// main sequence: reset, directed datagrams, random datagrams, drain
	initial begin
		byte_q_t q;
		int      dg;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single byte, all ones: short header
		send_datagram('{8'hff});
		// ends inside the tunnel id: partial tunnel id, zero bytes
		send_datagram('{8'h30, 8'h00, 8'h00, 8'h02, 8'hab, 8'hcd});
		// minimal good datagram with one payload byte
		send_datagram('{8'h30, 8'hff, 8'h00, 8'h01, 8'hde, 8'had, 8'hbe, 8'hef, 8'hff});
		// version 2 header: bad version, e also set
		send_datagram('{8'h54, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});

		dg = 0;
		while (normal_items < ITEM_TARGET) begin
			tx_idle_on = ($urandom_range(0, 2) != 0);
			q = make_datagram();
			normal_items += q.size();
			send_datagram(q);
			// sender pause: let every expected result drain out
			if (dg % 10 == 9) begin
				s_axis_tvalid <= 1'b0;
				while (sb.pending() > 0) @(posedge clk);
			end
			dg++;
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d datagrams, %0d bytes, %0d payload bytes under random stalls",
			sb.datagrams, sb.bytes_in, sb.payload_bytes);
		$display("status ok %0d, short header %0d, bad version %0d, extension %0d,",
			sb.status_count[ST_OK], sb.status_count[ST_SHORT_HEADER],
			sb.status_count[ST_BAD_VERSION], sb.status_count[ST_EXTENSION]);
		$display("short optional %0d, length mismatch %0d",
			sb.status_count[ST_SHORT_OPT], sb.status_count[ST_LEN_MISMATCH]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
